@@ hdl/tas_pkg.sv @@
// tas_pkg: shared constants and types of the ternary assignment store
// used by the channel interfaces, the store top level and its checker
package tas_pkg;

  localparam int MAX_VARS      = 1024;
  localparam int VARS_PER_WORD = 16;
  localparam int SLOT_W        = $clog2(VARS_PER_WORD);
  localparam int WORD_W        = 2 * VARS_PER_WORD;
  localparam int STORE_WORDS   = (MAX_VARS + VARS_PER_WORD - 1) / VARS_PER_WORD;
  localparam int ADDR_W        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int SHIFT_W       = SLOT_W + 1;

  localparam int VAR_INDEX_W   = 17;
  localparam int NUM_VARS_W    = 11;
  localparam int VAR_OFFSET_W  = 16;
  localparam int CFG_DATA_W    = 16;
  // adjusted index: wide enough for var_index - 1 - var_offset as a signed value
  localparam int ADJ_W         = VAR_INDEX_W + 2;

  localparam logic [WORD_W-1:0] ALL_UNDEFINED = {VARS_PER_WORD{2'b10}};
  localparam logic [NUM_VARS_W-1:0] NUM_VARS_RST = NUM_VARS_W'(1024);

  typedef logic [1:0] tern_t;
  localparam tern_t VAL_INVALID = 2'd3;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_VALUE = 2'd2
  } status_t;

  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_NUM_VARS   = 2'd0;
  localparam cfg_addr_t CFG_VAR_OFFSET = 2'd1;

endpackage

@@ hdl/tas_if.sv @@
// tas_in_if, tas_out_if: valid/ready channels of the ternary assignment store
// payload types come from tas_pkg
interface tas_in_if;
  import tas_pkg::*;
  logic                   valid;
  logic                   ready;
  cmd_t                   command;
  logic [VAR_INDEX_W-1:0] var_index;
  tern_t                  value;

  modport source (output valid, command, var_index, value, input ready);
  modport sink   (input valid, command, var_index, value, output ready);
endinterface

interface tas_out_if;
  import tas_pkg::*;
  logic    valid;
  logic    ready;
  tern_t   read_value;
  status_t status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

@@ hdl/tas_ram.sv @@
// tas_ram: generic single-write, single-read ram with registered read data
// no dependencies
module tas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/ternary_assignment_store.sv @@
// ternary_assignment_store: top level of the packed 2-bit ternary value store
// depends on tas_pkg, tas_in_if / tas_out_if and tas_ram
//
// Holds one ternary value (0 false, 1 true, 2 undefined) per variable, packed
// sixteen to a 32-bit word of a 64-entry ram, first variable in the top bits.
// in_if carries requests (command, 1-based var_index, value); every request
// gives exactly one transfer on out_if (read_value, status).
// cfg_we/cfg_addr/cfg_wdata set num_vars (index 0) and var_offset (index 1);
// write them only while no request is in flight.
// An accepted request is registered in the modify stage and then in the
// output register, which drives out_if.
// Throughput: one request per cycle unless out_if stalls. The ram read is
// issued at acceptance, the word is modified and written back in the modify
// stage; a same-word write by the prior request is forwarded from a register.
// Reset (rst_n low, synchronous) clears the pipeline and the per-word valid
// flags, so every variable reads as undefined; no clearing pass is needed.
// When out_if stalls, the result holds in the output register, the one
// request behind it waits in the modify stage and in_if.ready drops.
module ternary_assignment_store (
  input  logic                            clk,
  input  logic                            rst_n,
  tas_in_if.sink                          in_if,
  tas_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  tas_pkg::cfg_addr_t              cfg_addr,
  input  logic [tas_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tas_pkg::*;

  logic [NUM_VARS_W-1:0]   num_vars_r;
  logic [VAR_OFFSET_W-1:0] var_offset_r;

  logic [ADJ_W-1:0]  adj;
  logic [ADJ_W-1:0]  count;
  logic              in_range;
  logic              in_acc;
  status_t           pre_status;
  logic [ADDR_W-1:0] rd_addr;

  logic              s1_vld_r;
  cmd_t              s1_cmd_r;
  status_t           s1_status_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [SLOT_W-1:0] s1_slot_r;
  tern_t             s1_value_r;
  logic              s1_adv;

  logic [WORD_W-1:0]      ram_rdata;
  logic [WORD_W-1:0]      cur_word;
  logic [WORD_W-1:0]      new_word;
  logic [WORD_W-1:0]      fld_mask;
  logic [SHIFT_W-1:0]     sh;
  tern_t                  field;
  logic                   wr_en;

  logic                   fwd_vld_r;
  logic [ADDR_W-1:0]      fwd_addr_r;
  logic [WORD_W-1:0]      fwd_data_r;
  logic [STORE_WORDS-1:0] ent_vld_r;

  logic    out_vld_r;
  tern_t   read_value_r;
  status_t status_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r   <= NUM_VARS_RST;
      var_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NUM_VARS:   num_vars_r   <= cfg_wdata[NUM_VARS_W-1:0];
        CFG_VAR_OFFSET: var_offset_r <= cfg_wdata[VAR_OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // index adjust and range check at acceptance
  always_comb begin
    count = (ADJ_W'(num_vars_r) > ADJ_W'(MAX_VARS)) ? ADJ_W'(MAX_VARS)
                                                    : ADJ_W'(num_vars_r);
    adj = ADJ_W'(in_if.var_index) - ADJ_W'(1) - ADJ_W'(var_offset_r);
    in_range = !adj[ADJ_W-1] && (adj < count);
    if (!in_range) begin
      pre_status = ST_INDEX;
    end else if (in_if.command == CMD_WRITE && in_if.value == VAL_INVALID) begin
      pre_status = ST_VALUE;
    end else begin
      pre_status = ST_OK;
    end
    rd_addr = ADDR_W'(adj >> SLOT_W);
  end

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_if.command;
      s1_status_r <= pre_status;
      s1_addr_r   <= rd_addr;
      s1_slot_r   <= adj[SLOT_W-1:0];
      s1_value_r  <= in_if.value;
    end
  end

  tas_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_tas_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (new_word),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // modify stage: last written word wins, never-written words read undefined
  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_addr_r) begin
      cur_word = fwd_data_r;
    end else if (ent_vld_r[s1_addr_r]) begin
      cur_word = ram_rdata;
    end else begin
      cur_word = ALL_UNDEFINED;
    end
    // slot 0 sits in the top two bits
    sh       = {~s1_slot_r, 1'b0};
    field    = tern_t'(cur_word >> sh);
    fld_mask = WORD_W'(2'b11) << sh;
    new_word = (cur_word & ~fld_mask) | (WORD_W'(s1_value_r) << sh);
    wr_en    = s1_adv && s1_cmd_r == CMD_WRITE && s1_status_r == ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
      ent_vld_r <= '0;
    end else if (wr_en) begin
      fwd_vld_r            <= 1'b1;
      ent_vld_r[s1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_word;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_value_r <= (s1_cmd_r == CMD_READ && s1_status_r == ST_OK) ? field : '0;
      status_r     <= s1_status_r;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.read_value = read_value_r;
  assign out_if.status     = status_r;

endmodule

@@ hdl/tas_checker.sv @@
// tas_checker: port-level assertions on the ternary assignment store
// bound to ternary_assignment_store; uses tas_pkg status codes
module tas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] read_value,
  input logic [1:0] status
);
  import tas_pkg::*;

  // every accepted request is followed by a valid result after the modify stage and the output register
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("accepted request produced no result");

  // failed requests return no data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |-> (read_value == 2'd0))
    else $error("read_value nonzero on failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_INDEX || status == ST_VALUE))
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_value) && $stable(status)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ternary_assignment_store tas_checker u_tas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .read_value (out_if.read_value),
  .status     (out_if.status)
);

@@ verif/tas_checker.sv @@
`timescale 1ns / 1ps
// tas_tb_checker: predicts every store access and compares the result transfers
// watches the request/result channels and the config port; needs tas_pkg and tas_if
module tas_tb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  tas_in_if                              in_if,
  tas_out_if                             out_if,
  input  logic                           cfg_we,
  input  tas_pkg::cfg_addr_t             cfg_addr,
  input  logic [tas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending_count
);
  import tas_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    tern_t   read_value;
    status_t status;
  } access_result_t;

  logic [WORD_W-1:0]       value_words [STORE_WORDS];
  logic [NUM_VARS_W-1:0]   num_vars;
  logic [VAR_OFFSET_W-1:0] var_offset;
  access_result_t          pending_results [$];
  int                      fails = 0;
  int                      waiting = 0;

  assign fail_count    = fails;
  assign pending_count = waiting;

  // one access against the shadow store: returns its result, applies a write
  function automatic access_result_t access_store(cmd_t cmd, logic [VAR_INDEX_W-1:0] var_index,
                                                  tern_t value);
    access_result_t res;
    int             count;
    int             adj;
    int             word;
    int             shift;
    res.read_value = '0;
    res.status     = ST_OK;
    count = (int'(num_vars) > MAX_VARS) ? MAX_VARS : int'(num_vars);
    adj   = int'(var_index) - 1 - int'(var_offset);
    if (adj < 0 || adj >= count) begin
      res.status = ST_INDEX;
      return res;
    end
    word  = adj / VARS_PER_WORD;
    // first variable of a word sits in the top two bits
    shift = 2 * (VARS_PER_WORD - 1 - adj % VARS_PER_WORD);
    if (cmd == CMD_READ) begin
      res.read_value = value_words[word][shift +: 2];
    end else if (value == VAL_INVALID) begin
      res.status = ST_VALUE;
    end else begin
      value_words[word][shift +: 2] = value;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      foreach (value_words[w]) value_words[w] = ALL_UNDEFINED;
      num_vars   = NUM_VARS_RST;
      var_offset = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_NUM_VARS) begin
          num_vars = cfg_wdata[NUM_VARS_W-1:0];
        end else if (cfg_addr == CFG_VAR_OFFSET) begin
          var_offset = cfg_wdata[VAR_OFFSET_W-1:0];
        end
      end
      // compare before predicting so a new request never matches this transfer
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          if (fails < MAX_REPORTS) begin
            $display("checker: unexpected result read_value %0d status %0d",
                     out_if.read_value, out_if.status);
          end
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.read_value !== want.read_value || out_if.status !== want.status) begin
            if (fails < MAX_REPORTS) begin
              $display("checker: mismatch read_value exp %0d got %0d, status exp %0d got %0d",
                       want.read_value, out_if.read_value, want.status, out_if.status);
            end
            fails++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        pending_results.push_back(access_store(in_if.command, in_if.var_index, in_if.value));
      end
    end
    waiting = pending_results.size();
  end

endmodule

@@ verif/tb_ternary_assignment_store.sv @@
`timescale 1ns / 1ps
// tb_ternary_assignment_store: stimulus and verdict for the ternary assignment store
// drives requests and config writes, stalls the result side; checking in tas_tb_checker
module tb_ternary_assignment_store;
  import tas_pkg::*;

  localparam int        RANDOM_PHASES     = 10;
  localparam int        ITEMS_PER_PHASE   = 40;
  localparam int        LONG_STALL_CYCLES = 64;
  localparam int        DRAIN_CYCLES      = 8;
  localparam cfg_addr_t CFG_UNUSED_A      = 2'd2;
  localparam cfg_addr_t CFG_UNUSED_B      = 2'd3;

  typedef enum int {
    RX_FULL,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_addr_t             cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_count;
  bit                    long_stall_req;
  int                    burst_left;

  tas_in_if  in_if ();
  tas_out_if out_if ();

  ternary_assignment_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  tas_tb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (in_if),
    .out_if        (out_if),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: changing stall patterns, plus a long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    mode         = RX_FULL;
    mode_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        out_if.ready = 1'b0;
        repeat (LONG_STALL_CYCLES - 1) @(negedge clk);
        long_stall_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(5, 40);
        end
        mode_left--;
        case (mode)
          RX_FULL:   out_if.ready = 1'b1;
          RX_RANDOM: out_if.ready = 1'($urandom_range(0, 1));
          default:   out_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // entered and left at a falling edge; valid stays high across a burst
  task automatic send_request(cmd_t cmd, logic [VAR_INDEX_W-1:0] idx, tern_t val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid     = 1'b1;
    in_if.command   = cmd;
    in_if.var_index = idx;
    in_if.value     = val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // only while idle: no request offered and every result back
  task automatic write_reg(cfg_addr_t addr, logic [CFG_DATA_W-1:0] data);
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (pending_count != 0) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly in-range accesses, many on a hot window to hit back-to-back words
  task automatic send_random_access(int count_eff, int offset, int hot_base);
    int                     pick;
    int                     adj;
    logic [VAR_INDEX_W-1:0] idx;
    cmd_t                   cmd;
    tern_t                  val;
    pick = $urandom_range(0, 99);
    adj  = 0;
    if (count_eff > 0 && pick < 40) begin
      adj = int'((hot_base + $urandom_range(0, 31)) % count_eff);
    end else if (count_eff > 0 && pick < 70) begin
      adj = $urandom_range(0, count_eff - 1);
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0:       adj = -1;
        1:       adj = 0;
        2:       adj = count_eff - 1;
        default: adj = count_eff;
      endcase
    end
    if (pick >= 85) idx = VAR_INDEX_W'($urandom_range(0, 2 ** VAR_INDEX_W - 1));
    else idx = VAR_INDEX_W'(offset + 1 + adj);
    cmd = cmd_t'($urandom_range(0, 1));
    if (cmd == CMD_WRITE) begin
      val = ($urandom_range(0, 7) == 0) ? VAL_INVALID : tern_t'($urandom_range(0, 2));
    end else begin
      val = tern_t'($urandom_range(0, 3));
    end
    send_request(cmd, idx, val);
  endtask

  initial begin
    int num_data;
    int offset_data;
    int count_eff;
    int hot_base;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_NUM_VARS;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_READ;
    in_if.var_index = '0;
    in_if.value     = '0;
    long_stall_req  = 1'b0;
    burst_left      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: 1024 variables, no offset
    send_request(CMD_READ,  17'd1,      2'd0);
    send_request(CMD_WRITE, 17'd1,      2'd0);
    send_request(CMD_READ,  17'd1,      2'd0);
    send_request(CMD_WRITE, 17'd16,     2'd1);
    send_request(CMD_WRITE, 17'd17,     2'd0);
    send_request(CMD_READ,  17'd16,     2'd0);
    send_request(CMD_READ,  17'd17,     2'd0);
    send_request(CMD_WRITE, 17'd1024,   2'd1);
    send_request(CMD_READ,  17'd1024,   2'd0);
    send_request(CMD_READ,  17'd1025,   2'd0);
    send_request(CMD_WRITE, 17'd1025,   2'd1);
    send_request(CMD_READ,  17'd0,      2'd0);
    // out-of-range index wins over an invalid value
    send_request(CMD_WRITE, 17'd0,      VAL_INVALID);
    send_request(CMD_WRITE, 17'd5,      VAL_INVALID);
    send_request(CMD_READ,  17'd5,      2'd0);
    send_request(CMD_READ,  17'h1ffff,  VAL_INVALID);
    send_request(CMD_WRITE, 17'd2,      2'd2);
    send_request(CMD_READ,  17'd2,      VAL_INVALID);
    send_request(CMD_WRITE, 17'd3,      2'd1);
    send_request(CMD_WRITE, 17'd3,      2'd0);
    send_request(CMD_READ,  17'd3,      2'd0);
    // unused register indexes must leave count and offset alone
    write_reg(CFG_UNUSED_A, 16'hffff);
    write_reg(CFG_UNUSED_B, 16'h0005);
    send_request(CMD_READ,  17'd1024,   2'd0);
    send_request(CMD_READ,  17'd1,      2'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin num_data = 2047; offset_data = 0;     end
        1: begin num_data = 0;    offset_data = 0;     end
        2: begin num_data = 1;    offset_data = 65535; end
        3: begin num_data = 1024; offset_data = 65535; end
        4: begin num_data = 16;   offset_data = 40;    end
        default: begin
          case ($urandom_range(0, 4))
            0:       num_data = $urandom_range(1, 48);
            1:       num_data = $urandom_range(1000, 1100);
            2:       num_data = $urandom_range(0, 2047);
            3:       num_data = MAX_VARS;
            default: num_data = $urandom_range(1, 256);
          endcase
          offset_data = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 200);
        end
      endcase
      // upper data bits above the count field are junk
      write_reg(CFG_NUM_VARS, CFG_DATA_W'(num_data)
                              | (CFG_DATA_W'($urandom_range(0, 31)) << NUM_VARS_W));
      write_reg(CFG_VAR_OFFSET, CFG_DATA_W'(offset_data));
      count_eff = (num_data > MAX_VARS) ? MAX_VARS : num_data;
      hot_base  = (count_eff > 0) ? $urandom_range(0, count_eff - 1) : 0;
      if (p == 0 || p == 5) long_stall_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_access(count_eff, offset_data, hot_base);
    end

    in_if.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
